### hdl/stream_group_reverser_assert.svh
// Assertion macros used by the stream group reverser's sequencer, sgr_ctrl.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef STREAM_GROUP_REVERSER_ASSERT_SVH
`define STREAM_GROUP_REVERSER_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define SGR_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("stream_group_reverser: assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define SGR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("stream_group_reverser: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("stream_group_reverser: assertion failed");

`else

`define SGR_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define SGR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define SGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hdl/sgr_pkg.sv
`timescale 1ns / 1ps

package sgr_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int MAX_GROUP_DEF = 16;
  localparam int CFG_WIDTH = 5;
  localparam logic [CFG_WIDTH-1:0] GROUP_SIZE_RESET = 5'd1;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] word;
    logic                  list_end;
  } in_item_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] out_word;
    logic                  run_last;
    logic                  out_list_end;
  } out_item_t;

endpackage

### hdl/sgr_mem.sv
`timescale 1ns / 1ps

// Group buffer: one write port, one read port, registered read data.
module sgr_mem #(
  parameter int DEPTH = sgr_pkg::MAX_GROUP_DEF,
  parameter int AW    = 4
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [sgr_pkg::WORD_WIDTH-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [sgr_pkg::WORD_WIDTH-1:0] rdata
);

  logic [sgr_pkg::WORD_WIDTH-1:0] mem_r [DEPTH];
  logic [sgr_pkg::WORD_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/sgr_ctrl.sv
`timescale 1ns / 1ps
`include "stream_group_reverser_assert.svh"

// Fill counter and drain sequencer for the group buffer.
module sgr_ctrl #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF,
  parameter int AW        = 4,
  parameter int CW        = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sgr_pkg::CFG_WIDTH-1:0] group_size,
  input  logic                          in_valid,
  input  logic                          in_list_end,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_run_last,
  output logic                          out_list_end,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr
);

  localparam int KW = (CW > sgr_pkg::CFG_WIDTH) ? CW : sgr_pkg::CFG_WIDTH;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic            rev_r, rev_nxt;
  logic            end_r, end_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            run_last_r, run_last_nxt;
  logic            list_end_r, list_end_nxt;

  logic [KW-1:0]   gs_ext;
  logic [KW-1:0]   k_eff;
  logic [KW-1:0]   n_ext;
  logic            accept;
  logic            full_group;
  logic            rd_issue;
  logic            rd_last;

  // A group size of zero acts as one; sizes above the buffer depth saturate.
  always_comb begin
    gs_ext = KW'(group_size);
    if (gs_ext == '0) begin
      k_eff = KW'(1);
    end else if (gs_ext > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign accept     = in_valid && in_ready;
  assign n_ext      = KW'(fill_r) + KW'(1);
  assign full_group = (n_ext >= k_eff);
  assign rd_issue   = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign rd_last    = (rem_r == CW'(1));

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    rev_nxt       = rev_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !out_ready;
    run_last_nxt  = run_last_r;
    list_end_nxt  = list_end_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (full_group || in_list_end) begin
            state_nxt = ST_DRAIN;
            fill_nxt  = '0;
            rem_nxt   = n_ext[CW-1:0];
            rev_nxt   = full_group;
            end_nxt   = in_list_end;
            // Reversed groups start at the newest word, partial lists at the oldest.
            pos_nxt   = full_group ? fill_r : '0;
          end else begin
            fill_nxt = fill_r + AW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (rd_issue) begin
          out_valid_nxt = 1'b1;
          run_last_nxt  = rd_last;
          list_end_nxt  = rd_last && end_r;
          rem_nxt       = rem_r - CW'(1);
          pos_nxt       = rev_r ? (pos_r - AW'(1)) : (pos_r + AW'(1));
          if (rd_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r      <= pos_nxt;
    rem_r      <= rem_nxt;
    rev_r      <= rev_nxt;
    end_r      <= end_nxt;
    run_last_r <= run_last_nxt;
    list_end_r <= list_end_nxt;
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_run_last = run_last_r;
  assign out_list_end = list_end_r;
  assign mem_we       = accept;
  assign mem_waddr    = fill_r;
  assign mem_re       = rd_issue;
  assign mem_raddr    = pos_r;

  // A drain never runs with nothing left to read.
  `SGR_ASSERT_IMPLY(a_drain_nonempty, clk, rst_n, state_r == ST_DRAIN, rem_r != '0)
  // A completed group empties the buffer and starts a drain.
  `SGR_ASSERT_NEXT(a_group_drains, clk, rst_n, accept && full_group, (state_r == ST_DRAIN) && (fill_r == '0))
  // The read of the final word returns the sequencer to accepting requests.
  `SGR_ASSERT_NEXT(a_last_read_ends, clk, rst_n, rd_issue && rd_last, (state_r == ST_IDLE) && out_valid_r && run_last_r)

endmodule

### hdl/stream_group_reverser.sv
`timescale 1ns / 1ps
// Output: a request that completes a group (or ends a list) starts a drain of the n buffered
//   words, which then follow at one per cycle while out_ready is high.
// Input: a request that only fills the buffer leaves in_ready high for the next; after one that
//   releases n words, in_ready stays low until the single read port has read the last of them.
// Reset (synchronous, rst_n low): the buffer is empty, no result is pending, group_size is 1.

// Reverses a stream of words in groups of group_size words.
//
// Each accepted request writes its word into the group buffer at the current fill position.
// When the buffer holds group_size words, capped at MAX_GROUP, the sequencer reads them newest
// first; when a list ends on a partial group, it reads them back oldest first. While a
// group is being read out, in_ready is low, so a word can never be overwritten before it
// has been read. The read data register of the buffer doubles as the output register:
// a new read is only issued when the current result is taken or the output is empty.
module stream_group_reverser #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sgr_pkg::CFG_WIDTH-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sgr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sgr_pkg::out_item_t            out_data
);

  // Buffer index width and the width of a count that can reach MAX_GROUP.
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);

  logic [sgr_pkg::CFG_WIDTH-1:0]  group_size_r;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [sgr_pkg::WORD_WIDTH-1:0] mem_rdata;
  logic                           run_last;
  logic                           list_end;

  // Group size register; the user must write it only while no request is in flight (unchecked).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= sgr_pkg::GROUP_SIZE_RESET;
    end else if (cfg_we) begin
      group_size_r <= cfg_wdata;
    end
  end

  sgr_ctrl #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .group_size   (group_size_r),
    .in_valid     (in_valid),
    .in_list_end  (in_data.list_end),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_run_last (run_last),
    .out_list_end (list_end),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr)
  );

  sgr_mem #(
    .DEPTH (MAX_GROUP),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.word),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The word comes straight from the buffer's read register; the flags were
  // registered in the sequencer on the same read.
  always_comb begin
    out_data.out_word     = mem_rdata;
    out_data.run_last     = run_last;
    out_data.out_list_end = list_end;
  end

endmodule
